@@ hw/rtl/cfgbm_pkg.sv @@
package cfgbm_pkg;

  // Characters the scanner reacts to
  localparam logic [7:0] ChOpenBrace  = 8'h7B;
  localparam logic [7:0] ChCloseBrace = 8'h7D;
  localparam logic [7:0] ChQuote      = 8'h22;
  localparam logic [7:0] ChDash       = 8'h2D;
  localparam logic [7:0] ChLBracket   = 8'h5B;
  localparam logic [7:0] ChRBracket   = 8'h5D;
  localparam logic [7:0] ChBackslash  = 8'h5C;
  localparam logic [7:0] ChNewline    = 8'h0A;

  localparam int unsigned OutPosBits = 16;

  typedef enum logic [2:0] {
    ModeNormal = 3'd0,
    ModeString = 3'd1,
    ModeSkip   = 3'd2,
    ModeLine   = 3'd3,
    ModeBlock  = 3'd4,
    ModeOpen   = 3'd5
  } scan_mode_e;

  // Lexer flags carried from one byte to the next
  typedef struct packed {
    scan_mode_e mode;
    logic       pend_dash;
    logic       open_br;
    logic       pend_close;
    logic       done;
  } cfgbm_flags_t;

  // One result transaction
  typedef struct packed {
    logic                  valid;
    logic                  found;
    logic [OutPosBits-1:0] position;
  } cfgbm_res_t;

  localparam cfgbm_flags_t FlagsReset = '{
    mode:       ModeNormal,
    pend_dash:  1'b0,
    open_br:    1'b0,
    pend_close: 1'b0,
    done:       1'b1
  };

endpackage

@@ hw/rtl/cfgbm_step.sv @@
module cfgbm_step
  import cfgbm_pkg::*;
#(
  parameter int unsigned POS_BITS   = 16,
  parameter int unsigned DEPTH_BITS = 16
) (
  input  cfgbm_flags_t                  flags_i,
  input  logic [POS_BITS-1:0]           pos_i,
  input  logic signed [DEPTH_BITS-1:0]  depth_i,
  input  logic [7:0]                    ch_i,
  input  logic                          first_i,
  input  logic                          last_i,
  input  logic [15:0]                   start_i,
  output cfgbm_flags_t                  flags_o,
  output logic [POS_BITS-1:0]           pos_o,
  output logic signed [DEPTH_BITS-1:0]  depth_o,
  output cfgbm_res_t                    res_o
);

  localparam logic signed [DEPTH_BITS-1:0] DepthMax = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam logic signed [DEPTH_BITS-1:0] DepthMin = {1'b1, {(DEPTH_BITS-1){1'b0}}};
  localparam logic signed [DEPTH_BITS-1:0] DepthOne = DEPTH_BITS'(1);

  cfgbm_flags_t                 fl;
  logic [POS_BITS-1:0]          pos;
  logic signed [DEPTH_BITS-1:0] depth;
  logic                         active;
  logic                         match;

  always_comb begin
    // Start from cleared state on first, else from the carried state
    if (first_i) begin
      fl       = '{mode: ModeNormal, pend_dash: 1'b0, open_br: 1'b0,
                   pend_close: 1'b0, done: 1'b0};
      pos      = POS_BITS'(start_i);
      depth    = '0;
    end else begin
      fl       = flags_i;
      pos      = pos_i;
      depth    = depth_i;
    end
    active  = first_i || !flags_i.done;
    match   = 1'b0;
    flags_o = fl;
    depth_o = depth;
    pos_o   = pos + POS_BITS'(1);
    res_o   = '0;

    case (fl.mode)
      ModeSkip: begin
        flags_o.mode = ModeNormal;
      end
      ModeLine: begin
        if (ch_i == ChNewline) flags_o.mode = ModeNormal;
      end
      ModeBlock: begin
        if (ch_i == ChRBracket) begin
          flags_o.pend_close = !fl.pend_close;
          if (fl.pend_close) flags_o.mode = ModeNormal;
        end else begin
          flags_o.pend_close = 1'b0;
        end
      end
      ModeString: begin
        if (ch_i == ChQuote) flags_o.mode = ModeNormal;
      end
      ModeOpen: begin
        if (ch_i == ChLBracket) begin
          if (fl.open_br) begin
            flags_o.open_br    = 1'b0;
            flags_o.pend_close = 1'b0;
            flags_o.mode       = ModeBlock;
          end else begin
            flags_o.open_br = 1'b1;
          end
        end else begin
          flags_o.open_br = 1'b0;
          flags_o.mode    = (ch_i == ChNewline) ? ModeNormal : ModeLine;
        end
      end
      default: begin
        // Normal mode, and any unused code behaves as normal
        flags_o.pend_dash = 1'b0;
        flags_o.mode      = ModeNormal;
        if (fl.pend_dash && ch_i == ChDash) begin
          flags_o.open_br = 1'b0;
          flags_o.mode    = ModeOpen;
        end else if (ch_i == ChBackslash) begin
          flags_o.mode = ModeSkip;
        end else if (ch_i == ChQuote) begin
          flags_o.mode = ModeString;
        end else if (ch_i == ChDash) begin
          flags_o.pend_dash = 1'b1;
        end else if (ch_i == ChOpenBrace) begin
          if (depth != DepthMax) depth_o = depth + DepthOne;
        end else if (ch_i == ChCloseBrace) begin
          if (depth != DepthMin) begin
            depth_o = depth - DepthOne;
            match   = (depth == DepthOne);
          end
        end
      end
    endcase

    if (match) begin
      flags_o.done   = 1'b1;
      res_o.valid    = 1'b1;
      res_o.found    = 1'b1;
      res_o.position = OutPosBits'(pos);
    end else if (last_i) begin
      flags_o.done = 1'b1;
      res_o.valid  = 1'b1;
    end

    // Idle byte: leave all state as it was
    if (!active) begin
      flags_o = flags_i;
      pos_o   = pos_i;
      depth_o = depth_i;
      res_o   = '0;
    end
  end

endmodule

@@ hw/rtl/config_table_brace_matcher_unit.sv @@
// Closing-brace matcher for configuration script text.
//
// Input stream (s_axis_*): one text byte per transaction. tdata carries the
// byte and the start offset, tuser marks the first byte of a scan (clears the
// scan state and loads the offset), tlast marks the final byte of the text.
// Output stream (m_axis_*): at most one transaction per scan. tuser = 1 gives
// the absolute position of the closing brace that returns the depth to zero;
// tuser = 0 with tdata = 0 reports end of text without a match.
// Bytes arriving after a scan has finished, before the next first byte, are
// consumed and dropped.
//
// Pipeline: a byte is held in the input register; its result is loaded
// into the output register on the edge at which that byte advances.
// Throughput: one byte per clock while the result slot is free or draining,
// set by the combinational lexer step from input to state/result registers.
// Reset clears both stream registers and leaves the scanner idle until a
// first byte. When the receiver stalls with a result held, the input
// register holds its byte and s_axis_tready falls once it is full.
module config_table_brace_matcher_unit
  import cfgbm_pkg::*;
#(
  parameter int unsigned POS_BITS   = 16,
  parameter int unsigned DEPTH_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] ch, [23:8] start_offset
  input  logic        s_axis_tuser,   // [0] first
  input  logic        s_axis_tlast,   // last byte of the text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] position
  output logic        m_axis_tuser    // [0] found
);

  // Input register
  logic        in_valid_q, in_valid_d;
  logic [7:0]  ch_q;
  logic [15:0] start_q;
  logic        first_q, last_q;

  // Scan state
  cfgbm_flags_t                 flags_q, flags_d;
  logic [POS_BITS-1:0]          pos_q, pos_d;
  logic signed [DEPTH_BITS-1:0] depth_q, depth_d;

  // Result register
  logic        out_valid_q, out_valid_d;
  logic        found_q;
  logic [15:0] position_q;

  cfgbm_res_t res;
  logic       advance;
  logic       in_xact;

  // Advance the held byte when the result slot is free or draining
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_xact       = s_axis_tvalid && s_axis_tready;

  cfgbm_step #(
    .POS_BITS  (POS_BITS),
    .DEPTH_BITS(DEPTH_BITS)
  ) u_step (
    .flags_i (flags_q),
    .pos_i   (pos_q),
    .depth_i (depth_q),
    .ch_i    (ch_q),
    .first_i (first_q),
    .last_i  (last_q),
    .start_i (start_q),
    .flags_o (flags_d),
    .pos_o   (pos_d),
    .depth_o (depth_d),
    .res_o   (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xact) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (advance && res.valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state and scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= FlagsReset;
      pos_q       <= '0;
      depth_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        flags_q <= flags_d;
        pos_q   <= pos_d;
        depth_q <= depth_d;
      end
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xact) begin
      ch_q    <= s_axis_tdata[7:0];
      start_q <= s_axis_tdata[23:8];
      first_q <= s_axis_tuser;
      last_q  <= s_axis_tlast;
    end
    if (advance && res.valid) begin
      found_q    <= res.found;
      position_q <= res.position;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = position_q;
  assign m_axis_tuser  = found_q;

  // A not-found result always carries a zero position
  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 16'd0))
    else $error("not-found result with nonzero position");

  // Any issued result finishes the scan
  a_result_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res.valid) |=> flags_q.done)
    else $error("scan still open after result");

  // A finished scan leaves depth untouched until the next first byte
  a_idle_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flags_q.done && !(advance && first_q)) |=> $stable(depth_q))
    else $error("depth changed while idle");

endmodule
